// ----- design/fbds_pkg.sv -----
// Package for the filtered best-detection selector: candidate word layout,
// configuration bundle, register indexes and queue sizing.
// No dependencies.
package fbds_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_MIN_SCORE      = 3'd0;
	localparam logic [2:0] REG_REQ_POS_SIZE   = 3'd1;
	localparam logic [2:0] REG_CLASS_EN       = 3'd2;
	localparam logic [2:0] REG_TARGET_CLASS   = 3'd3;
	localparam logic [2:0] REG_LABEL_EN       = 3'd4;
	localparam logic [2:0] REG_TARGET_LABEL   = 3'd5;

	// Queue between front and back: address bits and depth
	localparam int QUEUE_AW    = 1;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	localparam int AREA_W = 30;

	// Configuration as seen by the classifier
	typedef struct packed {
		logic signed [15:0] score_floor;
		logic               size_pos_req;
		logic               class_filter_enable;
		logic [15:0]        target_class;
		logic               label_filter_enable;
		logic [15:0]        target_label_code;
	} cfg_t;

	// Classified candidate word handed from front to back
	typedef struct packed {
		logic               keep;
		logic               last;
		logic [AREA_W-1:0]  area;
		logic signed [15:0] score;
		logic signed [15:0] pos_u;
		logic signed [15:0] pos_v;
		logic signed [15:0] size_u;
		logic signed [15:0] size_v;
		logic [15:0]        cls_id;
		logic [15:0]        label_code;
	} cand_t;

	// Queue status toward the front and the checks
	typedef struct packed {
		logic                full;
		logic                empty;
		logic [QUEUE_AW:0]   level;
	} qstat_t;

endpackage

// ----- design/filtered_best_detection_select.sv -----
// Top level of the filtered best-detection selector: configuration registers,
// front classifier, queue and back selection. Uses fbds_pkg and fbds_* modules.
//
//   channel | handshake             | word
//   --------+-----------------------+---------------------------------------
//   in      | in_valid / in_stall   | one candidate, last marks end of list
//   out     | out_valid / out_stall | found plus the selected candidate
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (ready always high)
//
// One candidate per cycle is accepted while in_stall is low. A word passes the
// classify stage (filters and 15x15 area multiply), a two-word queue, then the
// select stage, whose result register raises out_valid when the last word pops.
// Reset clears control state and the configuration, which resets to zero.
// A result held by out_stall blocks the next last word at the queue head; the
// queue then holds that word and one more, the classify stage one more, before
// in_stall rises.
module filtered_best_detection_select import fbds_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] score,
	input  logic signed [15:0] pos_u,
	input  logic signed [15:0] pos_v,
	input  logic signed [15:0] size_u,
	input  logic signed [15:0] size_v,
	input  logic [15:0]        cls_id,
	input  logic [15:0]        label_code,
	input  logic [2:0]         non_finite_mask,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic signed [15:0] best_score_out,
	output logic signed [15:0] best_center_u_out,
	output logic signed [15:0] best_center_v_out,
	output logic signed [15:0] best_size_u_out,
	output logic signed [15:0] best_size_v_out,
	output logic [15:0]        best_class_out,
	output logic [15:0]        best_label_out
);

	cfg_t   cfg_q;
	qstat_t qstat;
	logic   push;
	logic   pop;
	cand_t  push_word;
	cand_t  head;
	logic   s1_busy;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_SCORE:    cfg_q.score_floor         <= cfg_data;
				REG_REQ_POS_SIZE: cfg_q.size_pos_req        <= cfg_data[0];
				REG_CLASS_EN:     cfg_q.class_filter_enable <= cfg_data[0];
				REG_TARGET_CLASS: cfg_q.target_class        <= cfg_data;
				REG_LABEL_EN:     cfg_q.label_filter_enable <= cfg_data[0];
				REG_TARGET_LABEL: cfg_q.target_label_code   <= cfg_data;
				default: ;
			endcase
		end
	end

	fbds_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.score           (score),
		.pos_u           (pos_u),
		.pos_v           (pos_v),
		.size_u          (size_u),
		.size_v          (size_v),
		.cls_id          (cls_id),
		.label_code      (label_code),
		.non_finite_mask (non_finite_mask),
		.last            (last),
		.qstat           (qstat),
		.push            (push),
		.push_word       (push_word),
		.s1_busy         (s1_busy)
	);

	fbds_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	fbds_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head              (head),
		.qstat             (qstat),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.found             (found),
		.best_score_out    (best_score_out),
		.best_center_u_out (best_center_u_out),
		.best_center_v_out (best_center_v_out),
		.best_size_u_out   (best_size_u_out),
		.best_size_v_out   (best_size_v_out),
		.best_class_out    (best_class_out),
		.best_label_out    (best_label_out)
	);

	// Queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n)
		qstat.level <= (QUEUE_AW+1)'(QUEUE_DEPTH))
		else $error("queue level beyond depth");

	// Front stalls when its stage is full and the queue has no room
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_busy && qstat.full) |-> in_stall)
		else $error("front took a word with nowhere to go");

	// Empty result carries zero fields
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (best_score_out == 16'sd0 && best_class_out == 16'd0
			&& best_label_out == 16'd0))
		else $error("empty result with nonzero fields");

	// Nothing pops from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

endmodule

// ----- design/fbds_front.sv -----
// Front of the selector: takes candidates, applies the filters, forms the area
// and registers the classified word for the queue. Uses fbds_pkg.
module fbds_front import fbds_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] score,
	input  logic signed [15:0] pos_u,
	input  logic signed [15:0] pos_v,
	input  logic signed [15:0] size_u,
	input  logic signed [15:0] size_v,
	input  logic [15:0]        cls_id,
	input  logic [15:0]        label_code,
	input  logic [2:0]         non_finite_mask,
	input  logic               last,
	input  qstat_t             qstat,
	output logic               push,
	output cand_t              push_word,
	output logic               s1_busy
);

	logic        valid_s1;
	cand_t       word_s1;
	cand_t       word_next;
	logic        score_ok;
	logic        center_ok;
	logic        size_ok;
	logic        class_ok;
	logic        label_ok;
	logic        area_ok;
	logic        advance;

	// Classify the incoming word
	always_comb begin
		score_ok  = !non_finite_mask[0] && (score >= cfg.score_floor);
		center_ok = !non_finite_mask[1] && !pos_u[15] && !pos_v[15];
		size_ok   = !cfg.size_pos_req ||
			(!non_finite_mask[2] && !size_u[15] && (size_u != 16'sd0) &&
			 !size_v[15] && (size_v != 16'sd0));
		class_ok  = !cfg.class_filter_enable || (cls_id == cfg.target_class);
		label_ok  = !cfg.label_filter_enable || (label_code == cfg.target_label_code);
		area_ok   = !non_finite_mask[2] && !size_u[15] && !size_v[15];

		word_next.keep       = score_ok && center_ok && size_ok && class_ok && label_ok;
		word_next.last       = last;
		word_next.area       = area_ok ?
			(AREA_W'(size_u[14:0]) * AREA_W'(size_v[14:0])) : '0;
		word_next.score      = score;
		word_next.pos_u      = pos_u;
		word_next.pos_v      = pos_v;
		word_next.size_u     = size_u;
		word_next.size_v     = size_v;
		word_next.cls_id     = cls_id;
		word_next.label_code = label_code;
	end

	// Hand the stage word to the queue when it has room
	assign push      = valid_s1 && !qstat.full;
	assign advance   = !valid_s1 || !qstat.full;
	assign in_stall  = !advance;
	assign push_word = word_s1;
	assign s1_busy   = valid_s1;

	// Hold or advance the stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	// Load the stage payload
	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			word_s1 <= word_next;
		end
	end

endmodule

// ----- design/fbds_queue.sv -----
// Short queue that decouples the classifier from the selection logic.
// Uses fbds_pkg for the word type and depth.
module fbds_queue import fbds_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  cand_t  push_word,
	input  logic   pop,
	output cand_t  head,
	output qstat_t qstat
);

	cand_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   level_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.level = level_q;
	assign qstat.full  = (level_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign qstat.empty = (level_q == '0);

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/fbds_back.sv -----
// Back of the selector: keeps the best candidate of the list and loads the
// result register at the end of each list. Uses fbds_pkg.
module fbds_back import fbds_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cand_t              head,
	input  qstat_t             qstat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic signed [15:0] best_score_out,
	output logic signed [15:0] best_center_u_out,
	output logic signed [15:0] best_center_v_out,
	output logic signed [15:0] best_size_u_out,
	output logic signed [15:0] best_size_v_out,
	output logic [15:0]        best_class_out,
	output logic [15:0]        best_label_out
);

	logic  have_q;
	cand_t best_q;
	cand_t pick;
	logic  take;
	logic  out_free;
	logic  out_valid_q;
	logic  found_q;
	cand_t res_q;

	// Decide whether the head word replaces the held best
	always_comb begin
		if (!have_q) begin
			take = head.keep;
		end else if (head.score != best_q.score) begin
			take = head.keep && (head.score > best_q.score);
		end else begin
			take = head.keep && (head.area > best_q.area);
		end
		pick = take ? head : best_q;
	end

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = !qstat.empty && (!head.last || out_free);

	// Track the best of the list; drop it after the end of list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (pop) begin
			have_q <= head.last ? 1'b0 : (have_q || take);
		end
	end

	always_ff @(posedge clk) begin
		if (pop && take) begin
			best_q <= head;
		end
	end

	// Result register valid: load at end of list, clear when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; zero when nothing was kept
	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			found_q <= have_q || take;
			res_q   <= (have_q || take) ? pick : '0;
		end
	end

	assign out_valid         = out_valid_q;
	assign found             = found_q;
	assign best_score_out    = res_q.score;
	assign best_center_u_out = res_q.pos_u;
	assign best_center_v_out = res_q.pos_v;
	assign best_size_u_out   = res_q.size_u;
	assign best_size_v_out   = res_q.size_v;
	assign best_class_out    = res_q.cls_id;
	assign best_label_out    = res_q.label_code;

endmodule
